FILE: hw/rtl/ssti_pkg.sv
`default_nettype none

package ssti_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [31:0]  angle;
    logic signed [15:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [15:0]  result_value;
    logic [1:0]          status;
    logic [8:0]          entry_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic clr_step;
    logic wr_rd;
    logic wr_do;
    logic mod_start;
    logic mod_cap;
    logic scan_step;
    logic sel;
    logic mul;
    logic div_start;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic div_idle;
    logic mod_rdy;
    logic cnt_zero;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssti_div.sv
`default_nettype none

module ssti_div #(
  parameter int DVW = 32,
  parameter int DSW = 9
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                idle,
  output logic [DVW-1:0]      quo
);

  localparam int CW = $clog2(DVW);

  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] dsr_r;
  logic [DSW:0]   trial;
  logic [DSW:0]   diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DVW-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(DVW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
      quo_r <= {quo_r[DVW-2:0], ge};
    end
  end

  assign idle = !busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ssti_datapath.sv
`default_nettype none

module ssti_datapath import ssti_pkg::*; #(
  parameter int FULL_TURN  = 360,
  parameter int VALUE_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts,
  input  wire in_t       in_data,
  output logic           out_valid,
  output out_t           out_data
);

  localparam int VB  = VALUE_BITS;
  localparam int VW1 = VB + 1;
  localparam int VW2 = VB + 2;
  localparam int KW  = $clog2(FULL_TURN);
  localparam int DKW = $clog2(FULL_TURN + 1);
  localparam int PW  = DKW + VW1;
  localparam int DVW = PW;
  localparam int RL  = $clog2(FULL_TURN);
  localparam int RS  = 31 + RL;
  localparam logic [63:0] RM = ((64'd1 << RS) + 64'(FULL_TURN - 1)) / 64'(FULL_TURN);
  localparam logic [31:0] RM32 = RM[31:0];

  in_t               item_r;
  logic [VB:0]       mem [FULL_TURN];
  logic [VB:0]       mem_q_r;
  logic              mem_we;
  logic [KW-1:0]     mem_wa;
  logic [VB:0]       mem_wd;
  logic              mem_re;
  logic [KW-1:0]     mem_ra;

  logic [KW-1:0]     addr_r;
  logic              rd_vld_r;
  logic [KW-1:0]     rd_key_r;
  logic [DKW-1:0]    cnt_r;
  logic [KW-1:0]     a_r;

  logic              have_first_r, have_lo_r, have_hi_r, hit_r;
  logic [KW-1:0]     first_k_r, last_k_r, lo_k_r, hi_k_r;
  logic signed [VB-1:0] first_v_r, last_v_r, lo_v_r, hi_v_r, hit_v_r;

  logic              direct_r;
  logic signed [VB-1:0] dval_r;
  logic signed [VB-1:0] v1_r;
  logic [DKW-1:0]    d_r;
  logic [DKW-1:0]    den_r;
  logic [VW1-1:0]    dvmag_r;
  logic              qneg_r;
  logic [PW-1:0]     prod_r;

  logic              mod_v1_r;
  logic              mod_v2_r;
  logic [DKW-1:0]    mq_r;
  logic [DKW-1:0]    mqd_r;

  logic              out_valid_r;
  out_t              out_data_r;

  logic              key_ok;
  logic [KW-1:0]     key_addr;
  logic [31:0]       vz;
  logic [VB-1:0]     wval;
  logic [31:0]       ang_mag;
  logic              q_vld;
  logic signed [VB-1:0] q_val;

  logic [63:0]       mprod_w;
  logic [DKW-1:0]    mrem;

  logic              div_start;
  logic [DVW-1:0]    div_dvd;
  logic [DKW-1:0]    div_dsr;
  logic              div_idle;
  logic [DVW-1:0]    div_quo;
  logic [DKW-1:0]    red;

  logic              sel_direct;
  logic signed [VB-1:0] sel_dval, v1, v2;
  logic [KW-1:0]     k1;
  logic [DKW-1:0]    den_w, d_w;
  logic signed [VW1-1:0] dv_w;
  logic [VW1-1:0]    q_mag;
  logic signed [VW2-1:0] qs, sum;
  logic              ovf;
  logic signed [VB-1:0] interp_v, res_v;
  logic signed [31:0] res_ext;
  logic [31:0]       cnt_ext;
  out_t              fin_w;

  assign key_ok   = !item_r.angle[31] && ($unsigned(item_r.angle) < 32'(FULL_TURN));
  assign key_addr = key_ok ? item_r.angle[KW-1:0] : '0;
  assign vz       = 32'($unsigned(item_r.value));
  assign wval     = vz[VB-1:0];
  assign ang_mag  = item_r.angle[31] ? (~$unsigned(item_r.angle) + 32'd1)
                                     : $unsigned(item_r.angle);
  assign q_vld    = mem_q_r[VB];
  assign q_val    = $signed(mem_q_r[VB-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // table store: valid flag on top of the value
  assign mem_we = cmd.clr_step | (cmd.wr_do & key_ok);
  assign mem_wa = cmd.clr_step ? addr_r : key_addr;
  assign mem_wd = cmd.clr_step ? '0 : {1'b1, wval};
  assign mem_re = cmd.wr_rd | cmd.scan_step;
  assign mem_ra = cmd.scan_step ? addr_r : key_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      cnt_r    <= '0;
      mod_v1_r <= 1'b0;
      mod_v2_r <= 1'b0;
    end else begin
      if (cmd.clr_step || cmd.scan_step) begin
        addr_r <= sts.addr_last ? '0 : addr_r + KW'(1);
      end
      rd_vld_r <= cmd.scan_step;
      mod_v1_r <= cmd.mod_start;
      mod_v2_r <= mod_v1_r;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.wr_do && key_ok && !q_vld) begin
        cnt_r <= cnt_r + DKW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_key_r <= addr_r;
    end
  end

  // angle reduction by reciprocal multiplication; only the low quotient bits matter
  assign mprod_w = 64'(ang_mag) * 64'(RM32);

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mq_r <= mprod_w[RS +: DKW];
    end
    if (mod_v1_r) begin
      mqd_r <= mq_r * DKW'(FULL_TURN);
    end
  end

  assign mrem = ang_mag[DKW-1:0] - mqd_r;
  assign red  = (item_r.angle[31] && (mrem != '0)) ? DKW'(FULL_TURN) - mrem : mrem;

  // serial divider for the interpolation quotient
  assign div_start = cmd.div_start;
  assign div_dvd   = prod_r;
  assign div_dsr   = den_r;

  ssti_div #(
    .DVW (DVW),
    .DSW (DKW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .idle     (div_idle),
    .quo      (div_quo)
  );

  // neighbour search, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      have_lo_r    <= 1'b0;
      have_hi_r    <= 1'b0;
      hit_r        <= 1'b0;
    end else if (cmd.mod_cap) begin
      have_first_r <= 1'b0;
      have_lo_r    <= 1'b0;
      have_hi_r    <= 1'b0;
      hit_r        <= 1'b0;
    end else if (rd_vld_r && q_vld) begin
      if (!have_first_r) begin
        have_first_r <= 1'b1;
      end
      if (rd_key_r < a_r) begin
        have_lo_r <= 1'b1;
      end
      if (rd_key_r > a_r) begin
        have_hi_r <= 1'b1;
      end
      if (rd_key_r == a_r) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_cap) begin
      a_r <= red[KW-1:0];
    end
    if (rd_vld_r && q_vld) begin
      if (!have_first_r) begin
        first_k_r <= rd_key_r;
        first_v_r <= q_val;
      end
      last_k_r <= rd_key_r;
      last_v_r <= q_val;
      if (rd_key_r < a_r) begin
        lo_k_r <= rd_key_r;
        lo_v_r <= q_val;
      end
      if (rd_key_r > a_r && !have_hi_r) begin
        hi_k_r <= rd_key_r;
        hi_v_r <= q_val;
      end
      if (rd_key_r == a_r) begin
        hit_v_r <= q_val;
      end
    end
  end

  always_comb begin
    sel_direct = 1'b0;
    sel_dval   = hit_v_r;
    k1         = lo_k_r;
    v1         = lo_v_r;
    v2         = hi_v_r;
    den_w      = DKW'(hi_k_r) - DKW'(lo_k_r);
    if (hit_r) begin
      sel_direct = 1'b1;
    end else if (!have_hi_r) begin
      // past the last key: wrap to first key plus a full turn
      k1    = last_k_r;
      v1    = last_v_r;
      v2    = first_v_r;
      den_w = DKW'(first_k_r) + DKW'(FULL_TURN) - DKW'(last_k_r);
    end else if (!have_lo_r) begin
      sel_direct = 1'b1;
      sel_dval   = hi_v_r;
    end
    d_w  = DKW'(a_r) - DKW'(k1);
    dv_w = VW1'(v2) - VW1'(v1);
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      direct_r <= sel_direct;
      dval_r   <= sel_dval;
      v1_r     <= v1;
      d_r      <= d_w;
      den_r    <= den_w;
      qneg_r   <= dv_w[VB];
      dvmag_r  <= dv_w[VB] ? $unsigned(-dv_w) : $unsigned(dv_w);
    end
    if (cmd.mul) begin
      prod_r <= PW'(d_r) * PW'(dvmag_r);
    end
  end

  assign q_mag    = div_quo[VW1-1:0];
  assign qs       = qneg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign sum      = VW2'(v1_r) + qs;
  assign ovf      = (sum[VB+1] != sum[VB-1]) || (sum[VB] != sum[VB-1]);
  assign interp_v = ovf ? (sum[VB+1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}})
                        : sum[VB-1:0];
  assign res_v    = direct_r ? dval_r : interp_v;
  assign res_ext  = 32'(res_v);
  assign cnt_ext  = 32'(cnt_r);

  always_comb begin
    fin_w.result_value = '0;
    fin_w.status       = ST_OK;
    fin_w.entry_count  = cnt_ext[8:0];
    case (item_r.cmd)
      CMD_WRITE: begin
        fin_w.status = key_ok ? ST_OK : ST_RANGE;
      end
      CMD_LOOKUP: begin
        if (sts.cnt_zero) begin
          fin_w.status = ST_EMPTY;
        end else begin
          fin_w.result_value = res_ext[15:0];
        end
      end
      default: begin
        fin_w.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r <= fin_w;
    end
  end

  assign sts.addr_last = addr_r == KW'(FULL_TURN - 1);
  assign sts.div_idle  = div_idle;
  assign sts.mod_rdy   = mod_v2_r;
  assign sts.cnt_zero  = cnt_r == '0;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ssti_ctrl.sv
`default_nettype none

module ssti_ctrl import ssti_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic [1:0] in_cmd,
  input  wire ctrl_sts_t sts,
  output logic           busy,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [13:0] {
    S_INIT = 14'h0001,
    S_IDLE = 14'h0002,
    S_CLR  = 14'h0004,
    S_WRD  = 14'h0008,
    S_WWR  = 14'h0010,
    S_LKP  = 14'h0020,
    S_MOD  = 14'h0040,
    S_SCAN = 14'h0080,
    S_DRN  = 14'h0100,
    S_SEL  = 14'h0200,
    S_MUL  = 14'h0400,
    S_DST  = 14'h0800,
    S_DIV  = 14'h1000,
    S_OUT  = 14'h2000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_cmd)
            CMD_WRITE:  state_nxt = S_WRD;
            CMD_LOOKUP: state_nxt = S_LKP;
            CMD_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_CLR;
            end
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_OUT;
        end
      end
      S_WRD: begin
        cmd.wr_rd = 1'b1;
        state_nxt = S_WWR;
      end
      S_WWR: begin
        cmd.wr_do = 1'b1;
        state_nxt = S_OUT;
      end
      S_LKP: begin
        if (sts.cnt_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_rdy) begin
          cmd.mod_cap = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_DRN;
        end
      end
      S_DRN: state_nxt = S_SEL;
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DST;
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_idle) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

`default_nettype wire

FILE: hw/rtl/sparse_sine_table_interpolator.sv
`default_nettype none

// Sparse sine table, keyed by whole degrees, with linear interpolation between
// stored keys. One request is taken when start is high and busy is low; its
// single result appears on out_data for exactly one cycle with out_valid high,
// and the receiver cannot stall it, so it must be captured on that cycle. The
// next request may be issued in the cycle the result is shown. Timing is set by
// a single-port sweep of the table store (one entry a cycle), a registered
// reciprocal-multiply angle reduction and a bit-serial divider for the
// interpolation quotient (DW = VALUE_BITS + 1 + bits of FULL_TURN, 26 steps at
// the default sizes, one quotient bit a cycle): a write reads and then writes
// its entry, a clear sweeps the whole store, an unused command and a lookup on
// an empty table go straight to the result, and any other lookup reduces the
// angle, sweeps the store, picks the neighbours, multiplies and divides. After
// reset the store is swept clear, busy high, before a request is taken.

module sparse_sine_table_interpolator import ssti_pkg::*; #(
  parameter int FULL_TURN  = 360,
  parameter int VALUE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ssti_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  ssti_datapath #(
    .FULL_TURN  (FULL_TURN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted request did not raise busy");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !busy)
    else $error("busy rose without a request");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.result_value == 16'sd0 && out_data.entry_count == 9'd0))
    else $error("empty-table result carries data");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ssti_pkg::*;

  localparam int         TURN       = 360;
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam int         N_ITEMS    = 1650;
  localparam longint     MAX_CYCLES = 6_000_000;
  localparam int         TAIL       = 600;

  typedef struct {
    in_t req;
    int  gap;
    bit  drain;
  } pend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  sparse_sine_table_interpolator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  pend_t              requests[$];
  out_t               owed_responses[$];
  logic signed [15:0] tbl_val [TURN];
  bit                 tbl_ok [TURN];
  int                 tbl_count = 0;
  int                 failures = 0;
  int                 queued = 0;
  bit                 calm = 1'b0;
  pend_t              cur;
  bit                 have = 1'b0;
  int                 hold = 0;
  longint             cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Behaviour of one request against the mirrored table.
  function automatic out_t table_response(in_t r);
    out_t   o;
    longint ang, a, k1, k2, v1, v2, den, acc;
    int     k, lo, hi, first, last;
    o = '0;
    ang = longint'($signed(r.angle));
    case (r.cmd)
      CMD_WRITE: begin
        if (ang < 0 || ang >= TURN) begin
          o.status = ST_RANGE;
        end else begin
          if (!tbl_ok[ang]) begin
            tbl_ok[ang] = 1'b1;
            tbl_count++;
          end
          tbl_val[ang] = r.value;
        end
      end
      CMD_LOOKUP: begin
        if (tbl_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          a = ang % TURN;
          if (a < 0) a += TURN;
          if (tbl_ok[a]) begin
            acc = tbl_val[a];
          end else begin
            lo = -1;
            hi = -1;
            first = -1;
            last = -1;
            for (k = 0; k < TURN; k++) begin
              if (tbl_ok[k]) begin
                if (first < 0) first = k;
                last = k;
                if (k < a) lo = k;
                if (k > a && hi < 0) hi = k;
              end
            end
            if (hi < 0) begin
              // past the last key: wrap onto the first key a full turn on
              k1 = last;
              v1 = tbl_val[last];
              k2 = first + TURN;
              v2 = tbl_val[first];
            end else begin
              k1 = lo;
              v1 = (lo < 0) ? 0 : tbl_val[lo];
              k2 = hi;
              v2 = tbl_val[hi];
            end
            if (hi >= 0 && lo < 0) begin
              acc = tbl_val[hi];
            end else begin
              den = k2 - k1;
              acc = (den <= 0) ? v1 : v1 + ((a - k1) * (v2 - v1)) / den;
            end
          end
          if (acc > 32767) acc = 32767;
          else if (acc < -32768) acc = -32768;
          o.result_value = acc[15:0];
        end
      end
      CMD_CLEAR: begin
        foreach (tbl_ok[n]) tbl_ok[n] = 1'b0;
        tbl_count = 0;
      end
      default: ;
    endcase
    o.entry_count = tbl_count[8:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 40);
    return $urandom_range(41, 500);
  endfunction

  function automatic void push_req(logic [1:0] cmd, logic [31:0] angle,
                                   logic [15:0] value, bit drain = 1'b0);
    pend_t p;
    p.req.cmd   = cmd;
    p.req.angle = angle;
    p.req.value = value;
    p.gap       = pick_gap();
    p.drain     = drain;
    requests.push_back(p);
    queued++;
  endfunction

  function automatic logic [31:0] rand_key();
    int r;
    r = $urandom_range(0, 19);
    if (r < 18) return $urandom_range(0, TURN - 1);
    if (r == 18) begin
      if ($urandom_range(0, 1)) return -int'($urandom_range(1, 4));
      return TURN + $urandom_range(0, 4);
    end
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_angle();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2) return $urandom_range(0, TURN - 1);
    if (r == 2) return int'($urandom_range(0, 4320)) - 2160;
    return $urandom;
  endfunction

  function automatic logic [15:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  initial begin
    int  keys [TURN];
    int  i, j, t, r;
    bit  filled;
    filled = 1'b0;

    push_req(CMD_LOOKUP, 32'd45, 16'd0);
    push_req(CMD_CLEAR, 32'd0, 16'd0);
    push_req(CMD_WRITE, 32'd100, 16'h7fff);
    push_req(CMD_WRITE, 32'd200, 16'h8000);
    push_req(CMD_LOOKUP, 32'd50, 16'd0);
    push_req(CMD_LOOKUP, 32'd150, 16'd0);
    push_req(CMD_LOOKUP, 32'd300, 16'd0);
    push_req(CMD_LOOKUP, 32'd100, 16'd0);
    push_req(CMD_LOOKUP, 32'h8000_0000, 16'hffff);
    push_req(CMD_LOOKUP, 32'h7fff_ffff, 16'd0);
    push_req(CMD_LOOKUP, -32'sd260, 16'd0);
    push_req(CMD_WRITE, 32'd100, 16'h1234);
    push_req(CMD_WRITE, -32'sd1, 16'h5555);
    push_req(CMD_WRITE, 32'd360, 16'd0);
    push_req(CMD_WRITE, 32'h8000_0000, 16'd0);
    push_req(CMD_WRITE, 32'h7fff_ffff, 16'hffff);
    push_req(CMD_SPARE, 32'hffff_ffff, 16'hffff);
    push_req(CMD_WRITE, 32'd0, 16'hc000);
    push_req(CMD_WRITE, 32'd359, 16'h4000);
    push_req(CMD_LOOKUP, 32'd358, 16'd0);
    push_req(CMD_LOOKUP, 32'd1, 16'd0);
    push_req(CMD_CLEAR, 32'hffff_ffff, 16'hffff, 1'b1);
    push_req(CMD_LOOKUP, 32'd10, 16'd0);

    while (queued < N_ITEMS) begin
      if ($urandom_range(0, 59) == 0) calm = ($urandom_range(0, 3) == 0);
      if (!filled && queued > 700) begin
        // populate every key once, in shuffled order
        foreach (keys[n]) keys[n] = n;
        for (i = TURN - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = keys[i];
          keys[i] = keys[j];
          keys[j] = t;
        end
        foreach (keys[n]) push_req(CMD_WRITE, keys[n], rand_value());
        repeat (10) push_req(CMD_LOOKUP, rand_angle(), 16'($urandom));
        filled = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 40) push_req(CMD_WRITE, rand_key(), rand_value());
      else if (r < 95)
        push_req(CMD_LOOKUP, rand_angle(), 16'($urandom), $urandom_range(0, 199) == 0);
      else if (r < 97) push_req(CMD_CLEAR, $urandom, 16'($urandom));
      else push_req(CMD_SPARE, $urandom, 16'($urandom));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (requests.size() != 0 || have || start || owed_responses.size() != 0);
    repeat (TAIL) @(posedge clk);
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    logic nxt_start;
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
      have = 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        owed_responses.push_back(table_response(in_data));
        nxt_start = 1'b0;
        have = 1'b0;
      end
      if (!have && requests.size() != 0) begin
        cur = requests.pop_front();
        have = 1'b1;
        hold = cur.gap;
      end
      if (have && !nxt_start) begin
        if (hold > 0) begin
          hold--;
        end else if (!cur.drain || owed_responses.size() == 0) begin
          in_data <= cur.req;
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (owed_responses.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = owed_responses.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 $signed(want.result_value), $signed(out_data.result_value));
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.entry_count, out_data.entry_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
